>>> sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operation codes, widths and the stage-to-stage record.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int OpW   = 16;
    localparam int PrdW  = 2 * OpW + 1;     // sum of two products
    localparam int DenW  = 2 * OpW + 1;
    localparam int OutW  = 40;
    localparam int FracN = 16;
    localparam int QW    = 2 * OpW + 2;     // integer quotient bits
    localparam int DivN  = QW + FracN;      // quotient bits produced

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // sign and magnitude of both result parts, with divisor and flags, before clamp
    typedef struct packed {
        logic            vld;
        logic            dz;
        logic            is_div;
        logic            nre;
        logic            nim;
        logic [PrdW-1:0] mre;
        logic [PrdW-1:0] mim;
        logic [DenW-1:0] den;
    } t_front;

endpackage

>>> sv/complex_arith_unit_top.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_top: complex add, subtract, multiply and divide
// Q8.8 operands in, saturated Q24.16 results out, one item per cycle.
// ----------------------------------------------------------------------------
// Accepts one item every cycle (busy stays low). Each result appears on the
// o_ ports for one cycle with o_done high, after passing through the product
// and sum stages, one stage per quotient bit of the divider (every operation
// passes through it to keep order) and one clamp stage. The receiver must
// take each result in the cycle it is shown.
module complex_arith_unit_top import cau_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_kind,
    input  logic signed [OpW-1:0]  i_a_re,
    input  logic signed [OpW-1:0]  i_a_im,
    input  logic signed [OpW-1:0]  i_b_re,
    input  logic signed [OpW-1:0]  i_b_im,
    output logic                   o_done,
    output logic signed [OutW-1:0] o_res_re,
    output logic signed [OutW-1:0] o_res_im,
    output logic                   o_div_zero,
    output logic                   o_saturated
);
    t_front          s_f0, s_f1;
    logic [DivN-1:0] s_qre, s_qim;

    assign busy = 1'b0;

    cau_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(start), .i_kind(i_kind),
        .i_a_re(i_a_re), .i_a_im(i_a_im), .i_b_re(i_b_re), .i_b_im(i_b_im),
        .o_front(s_f0)
    );

    cau_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_front(s_f0),
        .o_front(s_f1), .o_qre(s_qre), .o_qim(s_qim)
    );

    cau_clamp u_clamp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_front(s_f1),
        .i_qre(s_qre), .i_qim(s_qim), .o_vld(o_done),
        .o_re(o_res_re), .o_im(o_res_im), .o_dz(o_div_zero), .o_sat(o_saturated)
    );
endmodule

>>> sv/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: operand products and sums
// Two stages: six signed products, then sums as sign and magnitude.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [1:0]            i_kind,
    input  logic signed [OpW-1:0] i_a_re,
    input  logic signed [OpW-1:0] i_a_im,
    input  logic signed [OpW-1:0] i_b_re,
    input  logic signed [OpW-1:0] i_b_im,
    output t_front                o_front
);
    logic                  r_v1;
    t_op                   r_op1;
    logic signed [2*OpW-1:0] r_p0, r_p1, r_p2, r_p3, r_bb0, r_bb1;
    logic signed [OpW-1:0] r_ar, r_ai, r_br, r_bi;
    t_front                r_f, n_f;
    logic signed [PrdW:0]  s_re, s_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
        end
        r_op1 <= t_op'(i_kind);
        r_ar  <= i_a_re;
        r_ai  <= i_a_im;
        r_br  <= i_b_re;
        r_bi  <= i_b_im;
        r_p0  <= i_a_re * i_b_re;
        r_p1  <= i_a_im * i_b_im;
        r_p2  <= i_a_re * i_b_im;
        r_p3  <= i_a_im * i_b_re;
        r_bb0 <= i_b_re * i_b_re;
        r_bb1 <= i_b_im * i_b_im;
    end

    always_comb begin
        s_re = '0;
        s_im = '0;
        case (r_op1)
            OP_ADD: begin
                s_re = (PrdW+1)'(r_ar) * 256 + (PrdW+1)'(r_br) * 256;
                s_im = (PrdW+1)'(r_ai) * 256 + (PrdW+1)'(r_bi) * 256;
            end
            OP_SUB: begin
                s_re = (PrdW+1)'(r_ar) * 256 - (PrdW+1)'(r_br) * 256;
                s_im = (PrdW+1)'(r_ai) * 256 - (PrdW+1)'(r_bi) * 256;
            end
            OP_MUL: begin
                s_re = (PrdW+1)'(r_p0) - (PrdW+1)'(r_p1);
                s_im = (PrdW+1)'(r_p2) + (PrdW+1)'(r_p3);
            end
            default: begin
                s_re = (PrdW+1)'(r_p0) + (PrdW+1)'(r_p1);
                s_im = (PrdW+1)'(r_p3) - (PrdW+1)'(r_p2);
            end
        endcase
        n_f        = '0;
        n_f.vld    = r_v1;
        n_f.is_div = (r_op1 == OP_DIV);
        n_f.den    = DenW'($unsigned(r_bb0)) + DenW'($unsigned(r_bb1));
        n_f.dz     = n_f.is_div && (n_f.den == '0);
        n_f.nre    = s_re[PrdW];
        n_f.nim    = s_im[PrdW];
        n_f.mre    = s_re[PrdW] ? PrdW'(-s_re) : PrdW'(s_re);
        n_f.mim    = s_im[PrdW] ? PrdW'(-s_im) : PrdW'(s_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f.vld <= 1'b0;
        end else begin
            r_f.vld <= n_f.vld;
        end
        r_f.dz     <= n_f.dz;
        r_f.is_div <= n_f.is_div;
        r_f.nre    <= n_f.nre;
        r_f.nim    <= n_f.nim;
        r_f.mre    <= n_f.mre;
        r_f.mim    <= n_f.mim;
        r_f.den    <= n_f.den;
    end

    assign o_front = r_f;
endmodule

>>> sv/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div: pipelined restoring divider, both parts in parallel
// One quotient bit per stage; non-divide items pass through the same stages.
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_front i_front,
    output t_front o_front,
    output logic [DivN-1:0] o_qre,
    output logic [DivN-1:0] o_qim
);
    localparam int RW = DenW + 1;
    localparam int NW = PrdW + FracN;

    t_front            r_f  [DivN+1];
    logic [RW-1:0]     r_rr [DivN+1];
    logic [RW-1:0]     r_ri [DivN+1];
    logic [NW-1:0]     r_nr [DivN+1];
    logic [NW-1:0]     r_ni [DivN+1];
    logic [DivN-1:0]   r_qr [DivN+1];
    logic [DivN-1:0]   r_qi [DivN+1];

    always_comb begin
        r_f[0]  = i_front;
        r_rr[0] = '0;
        r_ri[0] = '0;
        r_nr[0] = {i_front.mre, FracN'(0)};
        r_ni[0] = {i_front.mim, FracN'(0)};
        r_qr[0] = '0;
        r_qi[0] = '0;
    end

    for (genvar k = 0; k < DivN; k++) begin : g_stage
        logic [RW-1:0] s_tr, s_ti;
        logic [RW-1:0] s_dd;
        logic          s_br, s_bi;
        always_comb begin
            s_dd = RW'(r_f[k].den);
            // quotient positions above the dividend width shift in zero dividend bits
            s_tr = {r_rr[k][RW-2:0], (k < DivN - NW) ? 1'b0 : r_nr[k][NW-1]};
            s_ti = {r_ri[k][RW-2:0], (k < DivN - NW) ? 1'b0 : r_ni[k][NW-1]};
            s_br = (s_tr >= s_dd) && (s_dd != '0);
            s_bi = (s_ti >= s_dd) && (s_dd != '0);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_f[k+1].vld <= 1'b0;
            end else begin
                r_f[k+1].vld <= r_f[k].vld;
            end
            r_f[k+1].dz     <= r_f[k].dz;
            r_f[k+1].is_div <= r_f[k].is_div;
            r_f[k+1].nre    <= r_f[k].nre;
            r_f[k+1].nim    <= r_f[k].nim;
            r_f[k+1].mre    <= r_f[k].mre;
            r_f[k+1].mim    <= r_f[k].mim;
            r_f[k+1].den    <= r_f[k].den;
            r_rr[k+1] <= s_br ? s_tr - s_dd : s_tr;
            r_ri[k+1] <= s_bi ? s_ti - s_dd : s_ti;
            r_nr[k+1] <= (k < DivN - NW) ? r_nr[k] : {r_nr[k][NW-2:0], 1'b0};
            r_ni[k+1] <= (k < DivN - NW) ? r_ni[k] : {r_ni[k][NW-2:0], 1'b0};
            r_qr[k+1] <= {r_qr[k][DivN-2:0], s_br};
            r_qi[k+1] <= {r_qi[k][DivN-2:0], s_bi};
        end
    end

    assign o_front = r_f[DivN];
    assign o_qre   = r_qr[DivN];
    assign o_qim   = r_qi[DivN];
endmodule

>>> sv/cau_clamp.sv
// ----------------------------------------------------------------------------
// cau_clamp: result selection and saturation
// Picks sum, quotient or zero magnitude, clamps to 40 bits, registers results.
// ----------------------------------------------------------------------------
module cau_clamp import cau_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_front                 i_front,
    input  logic [DivN-1:0]        i_qre,
    input  logic [DivN-1:0]        i_qim,
    output logic                   o_vld,
    output logic signed [OutW-1:0] o_re,
    output logic signed [OutW-1:0] o_im,
    output logic                   o_dz,
    output logic                   o_sat
);
    localparam int MW = (DivN > PrdW) ? DivN : PrdW;
    localparam logic [MW-1:0] PosLim = MW'((64'd1 << (OutW - 1)) - 64'd1);
    localparam logic [MW-1:0] NegLim = MW'(64'd1 << (OutW - 1));

    logic [MW-1:0]   s_mr, s_mi;
    logic            s_sr, s_si;
    logic [OutW-1:0] s_re, s_im;
    logic            r_vld, r_dz, r_sat;
    logic [OutW-1:0] r_re, r_im;

    function automatic logic [OutW-1:0] clamp(input logic neg, input logic [MW-1:0] mag,
                                              output logic sat);
        logic [MW-1:0] m;
        m   = mag;
        sat = 1'b0;
        if (!neg && mag > PosLim) begin
            m   = PosLim;
            sat = 1'b1;
        end else if (neg && mag > NegLim) begin
            m   = NegLim;
            sat = 1'b1;
        end
        clamp = neg ? OutW'(-m) : OutW'(m);
    endfunction

    always_comb begin
        if (i_front.dz) begin
            s_mr = '0;
            s_mi = '0;
        end else if (i_front.is_div) begin
            s_mr = MW'(i_qre);
            s_mi = MW'(i_qim);
        end else begin
            s_mr = MW'(i_front.mre);
            s_mi = MW'(i_front.mim);
        end
        s_re = clamp(i_front.nre, s_mr, s_sr);
        s_im = clamp(i_front.nim, s_mi, s_si);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_front.vld;
        end
        r_re  <= s_re;
        r_im  <= s_im;
        r_dz  <= i_front.dz;
        r_sat <= s_sr | s_si;
    end

    assign o_vld = r_vld;
    assign o_re  = r_re;
    assign o_im  = r_im;
    assign o_dz  = r_dz;
    assign o_sat = r_sat;
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for complex_arith_unit_top
// Drives directed and random operand pairs through the start/busy handshake,
// predicts each result and checks every o_done transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PosLim    = (longint'(1) << (OutW - 1)) - 1;
    localparam longint NegLim    = -(longint'(1) << (OutW - 1));
    localparam int     NumRandom = 1250;
    localparam int     CycleLimit = 400000;
    localparam int     DrainCycles = 80;

    typedef struct {
        logic signed [OutW-1:0] re;
        logic signed [OutW-1:0] im;
        logic                   dz;
        logic                   sat;
    } t_result;

    typedef struct {
        t_op                   op;
        logic signed [OpW-1:0] ar, ai, br, bi;
        bit                    typed;
        t_result               res;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             i_kind = OP_ADD;
    logic signed [OpW-1:0]  i_a_re = '0, i_a_im = '0, i_b_re = '0, i_b_im = '0;
    logic                   o_done;
    logic signed [OutW-1:0] o_res_re, o_res_im;
    logic                   o_div_zero, o_saturated;

    // expectation attached to the item currently on the inputs
    bit                     cur_typed = 1'b0;
    t_result                cur_res;

    t_result                pending_results[$];
    int                     errors = 0;
    int                     cycles = 0;
    int                     checked = 0;
    int                     op_count[4] = '{0, 0, 0, 0};
    int                     dz_seen = 0, sat_seen = 0;

    complex_arith_unit_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_a_re(i_a_re), .i_a_im(i_a_im),
        .i_b_re(i_b_re), .i_b_im(i_b_im),
        .o_done(o_done), .o_res_re(o_res_re), .o_res_im(o_res_im),
        .o_div_zero(o_div_zero), .o_saturated(o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result calc_result(t_op op, logic signed [OpW-1:0] ar,
                                            logic signed [OpW-1:0] ai,
                                            logic signed [OpW-1:0] br,
                                            logic signed [OpW-1:0] bi);
        longint xr, xi, yr, yi, r, im, den;
        t_result res;
        xr = ar; xi = ai; yr = br; yi = bi;
        r = 0; im = 0;
        res.dz = 1'b0; res.sat = 1'b0;
        case (op)
            OP_ADD: begin r = (xr + yr) * 256; im = (xi + yi) * 256; end
            OP_SUB: begin r = (xr - yr) * 256; im = (xi - yi) * 256; end
            OP_MUL: begin r = xr * yr - xi * yi; im = xr * yi + xi * yr; end
            default: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    res.dz = 1'b1;
                end else begin
                    // signed division truncates toward zero
                    r  = ((xr * yr + xi * yi) * 65536) / den;
                    im = ((xi * yr - xr * yi) * 65536) / den;
                end
            end
        endcase
        if (r > PosLim) begin r = PosLim; res.sat = 1'b1; end
        if (r < NegLim) begin r = NegLim; res.sat = 1'b1; end
        if (im > PosLim) begin im = PosLim; res.sat = 1'b1; end
        if (im < NegLim) begin im = NegLim; res.sat = 1'b1; end
        res.re = r[OutW-1:0];
        res.im = im[OutW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // record transfers and check results, both sampled at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected o_done", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (o_res_re !== want.re) report_mismatch("res_re", o_res_re, want.re);
                    if (o_res_im !== want.im) report_mismatch("res_im", o_res_im, want.im);
                    if (o_div_zero !== want.dz)
                        report_mismatch("div_zero", o_div_zero, want.dz);
                    if (o_saturated !== want.sat)
                        report_mismatch("saturated", o_saturated, want.sat);
                    if (want.dz) dz_seen++;
                    if (want.sat) sat_seen++;
                end
            end
            if (start && !busy) begin
                op_count[i_kind]++;
                if (cur_typed)
                    pending_results.push_back(cur_res);
                else
                    pending_results.push_back(calc_result(t_op'(i_kind), i_a_re, i_a_im,
                                                          i_b_re, i_b_im));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL complex_arith_unit_top");
            $finish;
        end
    end

    function automatic logic signed [OpW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3, 4: return OpW'($urandom_range(0, 1023)) - 16'sd512;
            default: return OpW'($urandom);
        endcase
    endfunction

    task automatic send_item(t_row row, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_kind    <= row.op;
        i_a_re    <= row.ar;
        i_a_im    <= row.ai;
        i_b_re    <= row.br;
        i_b_im    <= row.bi;
        cur_typed <= row.typed;
        cur_res   <= row.res;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_row make_row(t_op op, int ar, int ai, int br, int bi, bit typed,
                                      longint re, longint im, bit dz, bit sat);
        t_row row;
        row.op = op;
        row.ar = OpW'(ar); row.ai = OpW'(ai); row.br = OpW'(br); row.bi = OpW'(bi);
        row.typed = typed;
        row.res.re = re[OutW-1:0]; row.res.im = im[OutW-1:0];
        row.res.dz = dz; row.res.sat = sat;
        return row;
    endfunction

    initial begin
        t_row directed[$];
        t_row row;
        int   idle_pct;
        int   wait_cycles;

        directed.push_back(make_row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed.push_back(make_row(OP_ADD, 32767, 32767, 32767, 32767, 1,
                                    65534 * 256, 65534 * 256, 0, 0));
        directed.push_back(make_row(OP_ADD, -32768, -32768, -32768, -32768, 1,
                                    -65536 * 256, -65536 * 256, 0, 0));
        directed.push_back(make_row(OP_SUB, 32767, -32768, -32768, 32767, 1,
                                    65535 * 256, -65535 * 256, 0, 0));
        directed.push_back(make_row(OP_SUB, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed.push_back(make_row(OP_MUL, -32768, -32768, -32768, -32768, 1,
                                    0, longint'(1) << 31, 0, 0));
        directed.push_back(make_row(OP_MUL, 32767, 32767, -32768, 32767, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_MUL, 256, 0, 256, 0, 1, 65536, 0, 0, 0));
        directed.push_back(make_row(OP_DIV, 256, 0, 256, 0, 1, 65536, 0, 0, 0));
        directed.push_back(make_row(OP_DIV, 1234, -77, 0, 0, 1, 0, 0, 1, 0));
        directed.push_back(make_row(OP_DIV, 32767, 32767, 0, 0, 1, 0, 0, 1, 0));
        directed.push_back(make_row(OP_DIV, -32768, -32768, 0, 0, 1, 0, 0, 1, 0));
        // smallest divisor: the quotient is the numerator scaled up
        directed.push_back(make_row(OP_DIV, 32767, -32768, 1, 0, 1,
                                    longint'(32767) * 65536, longint'(-32768) * 65536,
                                    0, 0));
        directed.push_back(make_row(OP_DIV, -32768, 32767, 0, 1, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_DIV, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_DIV, 1, 0, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_DIV, -1, 0, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_DIV, 100, -200, -7, 13, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_MUL, 21845, -21846, 10922, 5461, 0, 0, 0, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) send_item(directed[n], 0);

        for (int n = 0; n < NumRandom; n++) begin
            case (n * 4 / NumRandom)
                0: idle_pct = 0;
                1: idle_pct = 76;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            row.op = t_op'($urandom_range(0, 3));
            row.ar = pick_operand();
            row.ai = pick_operand();
            row.br = pick_operand();
            row.bi = pick_operand();
            // force some zero and near-zero divisors
            if (row.op == OP_DIV && $urandom_range(0, 9) == 0) begin
                row.br = OpW'($urandom_range(0, 2));
                row.bi = '0;
            end
            row.typed = 1'b0;
            row.res = '{default: '0};
            send_item(row, idle_pct);
        end
        start     <= 1'b0;
        cur_typed <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        while (wait_cycles < DrainCycles) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        $display("covered %0d results: add %0d sub %0d mul %0d div %0d", checked,
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("divide-by-zero results %0d, clamped results %0d, mismatches %0d",
                 dz_seen, sat_seen, errors);
        if (errors == 0)
            $display("PASS complex_arith_unit_top");
        else
            $display("FAIL complex_arith_unit_top");
        $finish;
    end

endmodule

>>> filelist.f
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_div.sv
sv/cau_clamp.sv
sv/complex_arith_unit_top.sv
tb/sv/tb_top.sv
